// File: rtl/lcd_rotating_register_access_assert.svh
// Assertion macros for the LCD rotating register access block.
`ifndef LCD_ROTATING_REGISTER_ACCESS_ASSERT_SVH
`define LCD_ROTATING_REGISTER_ACCESS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during rst.
`define LCD_RRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcd_rra assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define LCD_RRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcd_rra assertion failed");

`else

`define LCD_RRA_ASSERT_NOW(lbl, ante, cons)
`define LCD_RRA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/lcd_rra_pkg.sv
// Types, constants and access decode tables for the LCD rotating register block.
package lcd_rra_pkg;

  localparam int POSITIONS = 12;
  localparam int NIB_W     = 4;
  localparam int WORD_W    = NIB_W * POSITIONS;
  localparam int POS_W     = 4;
  localparam int SUM_W     = POS_W + 1;
  localparam int IDX_W     = 6;
  localparam int ANN_W     = 12;
  localparam int ANN_NIBS  = ANN_W / NIB_W;

  typedef enum logic [1:0] {
    KIND_RD     = 2'd0,
    KIND_WR     = 2'd1,
    KIND_ANN_WR = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // register set bits
  localparam logic [2:0] REG_LO = 3'b001;
  localparam logic [2:0] REG_HI = 3'b010;
  localparam logic [2:0] REG_EX = 3'b100;
  localparam logic [2:0] REG_LH = REG_LO | REG_HI;
  localparam logic [2:0] REG_ALL = REG_LO | REG_HI | REG_EX;

  // read selector that returns the annunciator word
  localparam logic [3:0] SEL_ANN_RD = 4'h5;

  typedef struct packed {
    logic [2:0] regs;
    logic [3:0] cnt;
    logic       left;
  } access_t;

  // per-lane control: which digits of the word belong to this register
  typedef struct packed {
    logic       en;
    logic       wr;
    logic       left;
    logic [3:0] cnt;
    logic [1:0] stride;
    logic [1:0] offs;
  } lane_ctl_t;

  function automatic access_t rd_access(input logic [3:0] sel);
    access_t a;
    unique case (sel)
      4'h0: a = '{REG_LO,  4'd12, 1'b1};
      4'h1: a = '{REG_HI,  4'd12, 1'b1};
      4'h2: a = '{REG_EX,  4'd12, 1'b1};
      4'h3: a = '{REG_LH,  4'd6,  1'b1};
      4'h4: a = '{REG_ALL, 4'd4,  1'b1};
      4'h5: a = '{3'b000,  4'd0,  1'b1};
      4'h6: a = '{REG_EX,  4'd1,  1'b1};
      4'h7: a = '{REG_LO,  4'd1,  1'b0};
      4'h8: a = '{REG_HI,  4'd1,  1'b0};
      4'h9: a = '{REG_EX,  4'd1,  1'b0};
      4'ha: a = '{REG_LO,  4'd1,  1'b1};
      4'hb: a = '{REG_HI,  4'd1,  1'b1};
      4'hc: a = '{REG_LH,  4'd1,  1'b0};
      4'hd: a = '{REG_LH,  4'd1,  1'b1};
      4'he: a = '{REG_ALL, 4'd1,  1'b0};
      default: a = '{REG_ALL, 4'd1, 1'b1};
    endcase
    return a;
  endfunction

  function automatic access_t wr_access(input logic [3:0] sel);
    access_t a;
    unique case (sel)
      4'h0: a = '{REG_LO,  4'd12, 1'b1};
      4'h1: a = '{REG_HI,  4'd12, 1'b1};
      4'h2: a = '{REG_EX,  4'd12, 1'b1};
      4'h3: a = '{REG_LH,  4'd6,  1'b1};
      4'h4: a = '{REG_ALL, 4'd4,  1'b1};
      4'h5: a = '{REG_LH,  4'd6,  1'b0};
      4'h6: a = '{REG_ALL, 4'd4,  1'b0};
      4'h7: a = '{REG_LO,  4'd1,  1'b1};
      4'h8: a = '{REG_HI,  4'd1,  1'b1};
      4'h9: a = '{REG_EX,  4'd1,  1'b1};
      4'ha: a = '{REG_LO,  4'd1,  1'b0};
      4'hb: a = '{REG_HI,  4'd1,  1'b0};
      4'hc: a = '{REG_EX,  4'd1,  1'b0};
      4'hd: a = '{REG_LH,  4'd1,  1'b0};
      4'he: a = '{REG_ALL, 4'd1,  1'b1};
      default: a = '{REG_ALL, 4'd1, 1'b0};
    endcase
    return a;
  endfunction

  // lane k: stride is the number of selected registers, offset the selected ones below k
  function automatic lane_ctl_t make_ctl(input access_t a, input int k,
                                         input logic act, input logic wr);
    lane_ctl_t c;
    c.en     = act & a.regs[k];
    c.wr     = wr;
    c.left   = a.left;
    c.cnt    = a.cnt;
    c.stride = 2'(a.regs[0]) + 2'(a.regs[1]) + 2'(a.regs[2]);
    c.offs   = 2'b00;
    for (int i = 0; i < k; i++) begin
      c.offs = c.offs + 2'(a.regs[i]);
    end
    return c;
  endfunction

  // fold a sum of two positions back into 0..POSITIONS-1
  function automatic logic [POS_W-1:0] wrap_pos(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] w;
    w = (v >= SUM_W'(POSITIONS)) ? v - SUM_W'(POSITIONS) : v;
    return w[POS_W-1:0];
  endfunction

endpackage

// File: rtl/lcd_rra_req_if.sv
// Request channel: access kind, selector and CPU word.
interface lcd_rra_req_if;
  import lcd_rra_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [3:0]        sel;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, output kind, output sel, output word_in, input ready);
  modport sink   (input valid, input kind, input sel, input word_in, output ready);
endinterface

// File: rtl/lcd_rra_rsp_if.sv
// Response channel: updated CPU word.
interface lcd_rra_rsp_if;
  import lcd_rra_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_out;

  modport source (output valid, output word_out, input ready);
  modport sink   (input valid, input word_out, output ready);
endinterface

// File: rtl/lcd_rra_lane.sv
// One rotating character register: storage, digit read-out and rotate/shift-in update.
module lcd_rra_lane #(
  parameter int W = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lcd_rra_pkg::lane_ctl_t         ctl,
  input  logic                           upd,
  input  logic [lcd_rra_pkg::WORD_W-1:0] word,
  output logic [lcd_rra_pkg::WORD_W-1:0] rd_word,
  output logic [lcd_rra_pkg::POSITIONS-1:0] rd_mask
);
  import lcd_rra_pkg::*;

  logic [W-1:0]     r      [POSITIONS];
  logic [W-1:0]     r_next [POSITIONS];
  logic [NIB_W-1:0] dig    [POSITIONS];
  logic [IDX_W-1:0] dig_idx [POSITIONS];
  logic [POS_W-1:0] rd_pos [POSITIONS];
  logic [POSITIONS-1:0] dig_ok;

  // digit s of this register sits in word nibble s*stride+offs
  always_comb begin
    for (int s = 0; s < POSITIONS; s++) begin
      dig_idx[s] = IDX_W'(s) * IDX_W'(ctl.stride) + IDX_W'(ctl.offs);
      dig_ok[s]  = (dig_idx[s] < IDX_W'(POSITIONS)) && (POS_W'(s) < ctl.cnt);
      dig[s]     = dig_ok[s] ? word[NIB_W*dig_idx[s][POS_W-1:0] +: NIB_W] : '0;
      rd_pos[s]  = ctl.left ? POS_W'(POSITIONS - 1 - s) : POS_W'(s);
    end
  end

  // read-out: left end walks down from the top, right end up from 0
  always_comb begin
    rd_word = '0;
    rd_mask = '0;
    for (int s = 0; s < POSITIONS; s++) begin
      if (ctl.en && !ctl.wr && dig_ok[s]) begin
        rd_word[NIB_W*dig_idx[s][POS_W-1:0] +: NIB_W] = NIB_W'(r[rd_pos[s]]);
        rd_mask[dig_idx[s][POS_W-1:0]] = 1'b1;
      end
    end
  end

  // next contents after cnt rotations, with shifted-in digits on writes
  always_comb begin
    logic [POS_W-1:0] up_idx;
    logic [POS_W-1:0] dn_idx;
    logic [SUM_W-1:0] slot;
    for (int p = 0; p < POSITIONS; p++) begin
      up_idx = wrap_pos(SUM_W'(p) + SUM_W'(POSITIONS) - SUM_W'(ctl.cnt));
      dn_idx = wrap_pos(SUM_W'(p) + SUM_W'(ctl.cnt));
      slot   = '0;
      if (!ctl.wr) begin
        r_next[p] = ctl.left ? r[up_idx] : r[dn_idx];
      end else if (ctl.left) begin
        if (SUM_W'(p) + SUM_W'(ctl.cnt) >= SUM_W'(POSITIONS)) begin
          slot      = SUM_W'(p) + SUM_W'(ctl.cnt) - SUM_W'(POSITIONS);
          r_next[p] = dig[slot[POS_W-1:0]][W-1:0];
        end else begin
          r_next[p] = r[dn_idx];
        end
      end else begin
        if (POS_W'(p) < ctl.cnt) begin
          slot      = SUM_W'(ctl.cnt) - SUM_W'(1) - SUM_W'(p);
          r_next[p] = dig[slot[POS_W-1:0]][W-1:0];
        end else begin
          r_next[p] = r[up_idx];
        end
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POSITIONS; p++) begin
        r[p] <= '0;
      end
    end else if (upd && ctl.en) begin
      r <= r_next;
    end
  end

endmodule

// File: rtl/lcd_rotating_register_access.sv
// Top level of the LCD rotating register access block.
//
//   channel  dir  payload                     handshake
//   req      in   kind[1:0] sel[3:0] word_in  valid/ready
//   rsp      out  word_out[47:0]              valid/ready
//
// One item per cycle sustained while rsp is not stalled; each item passes through an input
// register, then a result register, with all digit movement done between them.
// Register state is read and updated as an item moves into the result
// register, so the next item always sees the previous one's effect.
// rst (synchronous) clears all character registers and annunciators.
// A stalled rsp holds the result; req stays open while the input stage can drain.
`include "lcd_rotating_register_access_assert.svh"

module lcd_rotating_register_access (
  input logic           clk,
  input logic           rst,
  lcd_rra_req_if.sink   req,
  lcd_rra_rsp_if.source rsp
);
  import lcd_rra_pkg::*;

  logic              s1_valid;
  kind_t             s1_kind;
  logic [3:0]        s1_sel;
  logic [WORD_W-1:0] s1_word;

  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic [WORD_W-1:0] word_next;
  logic [ANN_W-1:0]  ann;

  logic      adv;
  logic      is_rd;
  logic      is_wr;
  logic      ann_rd;
  logic      ann_wr;
  access_t   acc;
  lane_ctl_t ctl_lo;
  lane_ctl_t ctl_hi;
  lane_ctl_t ctl_ex;

  logic [WORD_W-1:0]    rd_lo;
  logic [WORD_W-1:0]    rd_hi;
  logic [WORD_W-1:0]    rd_ex;
  logic [POSITIONS-1:0] mask_lo;
  logic [POSITIONS-1:0] mask_hi;
  logic [POSITIONS-1:0] mask_ex;

  // handshake
  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;
  assign rsp.valid = out_valid;
  assign rsp.word_out = out_word;

  // access decode
  always_comb begin
    is_rd  = (s1_kind == KIND_RD);
    is_wr  = (s1_kind == KIND_WR);
    ann_wr = (s1_kind == KIND_ANN_WR);
    ann_rd = is_rd && (s1_sel == SEL_ANN_RD);
    acc    = is_rd ? rd_access(s1_sel) : wr_access(s1_sel);
    ctl_lo = make_ctl(acc, 0, is_rd || is_wr, is_wr);
    ctl_hi = make_ctl(acc, 1, is_rd || is_wr, is_wr);
    ctl_ex = make_ctl(acc, 2, is_rd || is_wr, is_wr);
  end

  lcd_rra_lane #(.W(4)) u_lo (
    .clk(clk), .rst(rst), .ctl(ctl_lo), .upd(adv), .word(s1_word),
    .rd_word(rd_lo), .rd_mask(mask_lo)
  );

  lcd_rra_lane #(.W(4)) u_hi (
    .clk(clk), .rst(rst), .ctl(ctl_hi), .upd(adv), .word(s1_word),
    .rd_word(rd_hi), .rd_mask(mask_hi)
  );

  lcd_rra_lane #(.W(1)) u_ex (
    .clk(clk), .rst(rst), .ctl(ctl_ex), .upd(adv), .word(s1_word),
    .rd_word(rd_ex), .rd_mask(mask_ex)
  );

  // merge read digits into the word; untouched nibbles pass through
  always_comb begin
    word_next = s1_word;
    for (int j = 0; j < POSITIONS; j++) begin
      if (mask_lo[j]) begin
        word_next[NIB_W*j +: NIB_W] = rd_lo[NIB_W*j +: NIB_W];
      end else if (mask_hi[j]) begin
        word_next[NIB_W*j +: NIB_W] = rd_hi[NIB_W*j +: NIB_W];
      end else if (mask_ex[j]) begin
        word_next[NIB_W*j +: NIB_W] = rd_ex[NIB_W*j +: NIB_W];
      end
    end
    if (ann_rd) begin
      word_next[ANN_W-1:0] = ann;
    end
  end

  // control and annunciator state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      ann       <= '0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (!out_valid || rsp.ready) begin
        out_valid <= s1_valid;
      end
      if (adv && ann_wr) begin
        ann <= s1_word[ANN_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_kind <= kind_t'(req.kind);
      s1_sel  <= req.sel;
      s1_word <= req.word_in;
    end
    if (adv) begin
      out_word <= word_next;
    end
  end

  // checks
  `LCD_RRA_ASSERT_NOW(a_ready_when_free, !out_valid, req.ready)
  `LCD_RRA_ASSERT_NEXT(a_ann_hold_on_stall, out_valid && !rsp.ready, $stable(ann))
  `LCD_RRA_ASSERT_NEXT(a_write_passes_word, adv && s1_kind != KIND_RD, out_word == $past(s1_word))

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the LCD rotating register access block.
module tb;
  import lcd_rra_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  // one decoded selector: registers touched, digits per register, end used
  typedef struct packed {
    logic [2:0] regs;
    logic [3:0] count;
    logic       from_left;
  } shift_plan_t;

  logic clk = 1'b0;
  logic rst;

  lcd_rra_req_if req_ch ();
  lcd_rra_rsp_if rsp_ch ();

  lcd_rotating_register_access u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // selector decode for selected reads; empty register set means annunciator read
  function automatic shift_plan_t read_plan(input logic [3:0] s);
    shift_plan_t p;
    case (s)
      4'h0: p = '{REG_LO,  4'd12, 1'b1};
      4'h1: p = '{REG_HI,  4'd12, 1'b1};
      4'h2: p = '{REG_EX,  4'd12, 1'b1};
      4'h3: p = '{REG_LH,  4'd6,  1'b1};
      4'h4: p = '{REG_ALL, 4'd4,  1'b1};
      SEL_ANN_RD: p = '{3'b000, 4'd0, 1'b1};
      4'h6: p = '{REG_EX,  4'd1,  1'b1};
      4'h7: p = '{REG_LO,  4'd1,  1'b0};
      4'h8: p = '{REG_HI,  4'd1,  1'b0};
      4'h9: p = '{REG_EX,  4'd1,  1'b0};
      4'ha: p = '{REG_LO,  4'd1,  1'b1};
      4'hb: p = '{REG_HI,  4'd1,  1'b1};
      4'hc: p = '{REG_LH,  4'd1,  1'b0};
      4'hd: p = '{REG_LH,  4'd1,  1'b1};
      4'he: p = '{REG_ALL, 4'd1,  1'b0};
      default: p = '{REG_ALL, 4'd1, 1'b1};
    endcase
    return p;
  endfunction

  // selector decode for selected writes
  function automatic shift_plan_t write_plan(input logic [3:0] s);
    shift_plan_t p;
    case (s)
      4'h0: p = '{REG_LO,  4'd12, 1'b1};
      4'h1: p = '{REG_HI,  4'd12, 1'b1};
      4'h2: p = '{REG_EX,  4'd12, 1'b1};
      4'h3: p = '{REG_LH,  4'd6,  1'b1};
      4'h4: p = '{REG_ALL, 4'd4,  1'b1};
      4'h5: p = '{REG_LH,  4'd6,  1'b0};
      4'h6: p = '{REG_ALL, 4'd4,  1'b0};
      4'h7: p = '{REG_LO,  4'd1,  1'b1};
      4'h8: p = '{REG_HI,  4'd1,  1'b1};
      4'h9: p = '{REG_EX,  4'd1,  1'b1};
      4'ha: p = '{REG_LO,  4'd1,  1'b0};
      4'hb: p = '{REG_HI,  4'd1,  1'b0};
      4'hc: p = '{REG_EX,  4'd1,  1'b0};
      4'hd: p = '{REG_LH,  4'd1,  1'b0};
      4'he: p = '{REG_ALL, 4'd1,  1'b1};
      default: p = '{REG_ALL, 4'd1, 1'b0};
    endcase
    return p;
  endfunction

  // shadow of the display registers plus the queue of CPU words still owed
  class lcd_word_scoreboard;
    bit [3:0]        digits [3][POSITIONS];
    bit [ANN_W-1:0]  annun;
    bit [WORD_W-1:0] owed_words [$];
    int              errors;

    // up: each position takes the one below, position 0 takes the old top
    function void rotate_reg(input int k, input bit up);
      bit [3:0] t;
      if (up) begin
        t = digits[k][POSITIONS-1];
        for (int i = POSITIONS - 1; i > 0; i--) digits[k][i] = digits[k][i-1];
        digits[k][0] = t;
      end else begin
        t = digits[k][0];
        for (int i = 0; i < POSITIONS - 1; i++) digits[k][i] = digits[k][i+1];
        digits[k][POSITIONS-1] = t;
      end
    endfunction

    function void note_request(input kind_t kind, input bit [3:0] sel,
                               input bit [WORD_W-1:0] w);
      shift_plan_t p;
      int          j;
      bit [3:0]    v;
      j = 0;
      case (kind)
        KIND_RD: begin
          p = read_plan(sel);
          if (p.regs == 3'b000) begin
            w[ANN_W-1:0] = annun;
          end else begin
            for (int i = 0; i < p.count; i++)
              for (int k = 0; k < 3; k++)
                if (p.regs[k]) begin
                  v = p.from_left ? digits[k][POSITIONS-1] : digits[k][0];
                  w[NIB_W*(j % POSITIONS) +: NIB_W] = v;
                  j++;
                  rotate_reg(k, p.from_left);
                end
          end
        end
        KIND_WR: begin
          p = write_plan(sel);
          for (int i = 0; i < p.count; i++)
            for (int k = 0; k < 3; k++)
              if (p.regs[k]) begin
                v = w[NIB_W*(j % POSITIONS) +: NIB_W];
                j++;
                rotate_reg(k, !p.from_left);
                // extra-bit register keeps bit 0 only
                if (k == 2) v = {3'b000, v[0]};
                if (p.from_left) digits[k][POSITIONS-1] = v;
                else digits[k][0] = v;
              end
        end
        KIND_ANN_WR: annun = w[ANN_W-1:0];
        default: ;
      endcase
      owed_words.push_back(w);
    endfunction

    function void check_word(input bit [WORD_W-1:0] got);
      bit [WORD_W-1:0] want;
      if (owed_words.size() == 0) begin
        $display("%0t: word_out %h arrived with no item outstanding", $time, got);
        errors++;
      end else begin
        want = owed_words.pop_front();
        if (want !== got) begin
          $display("%0t: word_out mismatch: expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  lcd_word_scoreboard sb;
  int idle_run = 0;

  // monitor: sample both handshakes at the rising edge; stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(kind_t'(req_ch.kind), req_ch.sel, req_ch.word_in);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_word(rsp_ch.word_out);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_run = 0;
      else
        idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("lcd_rotating_register_access regression: fail");
        $finish;
      end
    end
  end

  // receiver back-pressure: a random mode and pattern are drawn for each period
  int          stall_mode  = 0;
  int          stall_left  = 0;
  int          stall_phase = 0;
  logic [7:0]  stall_pat   = 8'hff;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_pat  = 8'($urandom) | 8'h01;
      stall_left = 97;
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= stall_pat[stall_phase % 8];
      default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // present one item and hold it until accepted
  task automatic drive_item(input kind_t k, input logic [3:0] s,
                            input logic [WORD_W-1:0] w);
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= k;
    req_ch.sel     <= s;
    req_ch.word_in <= w;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // sender gap with junk on the payload
  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= 2'($urandom);
      req_ch.sel     <= 4'($urandom);
      req_ch.word_in <= WORD_W'({$urandom, $urandom});
    end
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return ALL_ONES;
      default: return WORD_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic kind_t random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return KIND_RD;
    if (r < 85) return KIND_WR;
    if (r < 93) return KIND_ANN_WR;
    return KIND_NONE;
  endfunction

  initial begin
    int burst_left;
    sb = new();
    rst = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_RD;
    req_ch.sel     = '0;
    req_ch.word_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: full-register writes, annunciators, every read selector but 4'ha and 4'hb
    drive_item(KIND_WR, 4'h0, ALL_ONES);
    drive_item(KIND_WR, 4'h1, 48'hfedc_ba98_7654);
    drive_item(KIND_WR, 4'h2, ALL_ONES);              // extra bits keep bit 0
    drive_item(KIND_ANN_WR, 4'h0, ALL_ONES);
    drive_item(KIND_RD, SEL_ANN_RD, '0);
    drive_item(KIND_ANN_WR, 4'hf, 48'h1234_5678_9abc);
    drive_item(KIND_RD, SEL_ANN_RD, ALL_ONES);
    drive_item(KIND_RD, 4'h0, '0);
    drive_item(KIND_RD, 4'h1, '0);
    drive_item(KIND_RD, 4'h2, ALL_ONES);
    drive_item(KIND_RD, 4'h3, '0);
    drive_item(KIND_RD, 4'h4, ALL_ONES);
    drive_item(KIND_WR, 4'h3, 48'h0123_4567_89ab);
    drive_item(KIND_WR, 4'h4, 48'ha5a5_5a5a_f00f);
    drive_item(KIND_WR, 4'h5, 48'h3c3c_c3c3_1e1e);
    drive_item(KIND_WR, 4'h6, ALL_ONES);
    drive_item(KIND_RD, 4'h6, '0);
    drive_item(KIND_RD, 4'h7, '0);
    drive_item(KIND_RD, 4'h8, ALL_ONES);
    drive_item(KIND_RD, 4'h9, ALL_ONES);
    drive_item(KIND_RD, 4'hc, '0);
    drive_item(KIND_RD, 4'hd, '0);
    drive_item(KIND_RD, 4'he, ALL_ONES);
    drive_item(KIND_RD, 4'hf, '0);
    drive_item(KIND_NONE, 4'hf, ALL_ONES);            // kind three changes nothing

    // random: bursts of random length separated by short gaps
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        sender_gap($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      drive_item(random_kind(), 4'($urandom_range(0, 15)), random_word());
    end
    sender_gap(1);

    // drain, then allow for the pipeline depth
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("lcd_rotating_register_access regression: pass");
    end else begin
      $display("lcd_rotating_register_access regression: fail");
    end
    $finish;
  end

endmodule
